@@ rtl/core/tec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tec_pkg;

  // Text class bits (OR-able)
  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_T    = 3'd1;
  localparam logic [2:0] CLS_I    = 3'd2;
  localparam logic [2:0] CLS_X    = 3'd4;

  // Result type codes
  localparam logic [2:0] DT_ASCII   = 3'd0;
  localparam logic [2:0] DT_ISO8859 = 3'd1;
  localparam logic [2:0] DT_EXT     = 3'd2;
  localparam logic [2:0] DT_UTF     = 3'd3;
  localparam logic [2:0] DT_BINARY  = 3'd4;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified item as it sits in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] cls;
    logic       last_byte;
  } tec_entry_t;

  // Handshake from the queue head to the back end
  typedef struct packed {
    logic       valid;
    tec_entry_t entry;
  } tec_head_t;

  // Per-byte text class
  function automatic logic [2:0] text_class(input logic [7:0] b);
    logic [2:0] c;
    if (b >= 8'hA0) begin
      c = CLS_I;
    end else if (b >= 8'h80) begin
      c = (b == 8'h85) ? CLS_T : CLS_X;
    end else if (b >= 8'h20) begin
      c = (b == 8'h7F) ? CLS_NONE : CLS_T;
    end else if (b == 8'h07 || b == 8'h08 || b == 8'h09 || b == 8'h0A ||
                 b == 8'h0C || b == 8'h0D || b == 8'h1B) begin
      c = CLS_T;
    end else begin
      c = CLS_NONE;
    end
    return c;
  endfunction

  // Largest overlong value for a given UTF-8 sequence length
  function automatic logic [30:0] overlong_bound(input logic [2:0] len);
    logic [30:0] v;
    case (len)
      3'd2:    v = 31'h0000007F;
      3'd3:    v = 31'h000007FF;
      3'd4:    v = 31'h0000FFFF;
      3'd5:    v = 31'h001FFFFF;
      3'd6:    v = 31'h03FFFFFF;
      default: v = 31'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tec_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tec_front (
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  input  wire logic               q_full,
  output logic                    in_stall,
  output logic                    push,
  output tec_pkg::tec_entry_t     push_entry
);
  import tec_pkg::*;

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte on the way in
  always_comb begin
    push_entry.data_byte = in_data_byte;
    push_entry.cls       = text_class(in_data_byte);
    push_entry.last_byte = in_last_byte;
  end

endmodule

`default_nettype wire

@@ rtl/core/tec_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tec_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tec_pkg::tec_entry_t  push_entry,
  input  wire logic                 pop_ready,
  output logic                      q_full,
  output tec_pkg::tec_head_t        head
);
  import tec_pkg::*;

  tec_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                pop;

  assign q_full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign pop        = head.valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tec_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tec_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tec_pkg::tec_head_t  head,
  input  wire logic                out_stall,
  output logic                     pop_ready,
  output logic                     out_valid,
  output logic [2:0]               out_data_type
);
  import tec_pkg::*;

  localparam logic [1:0] BOM_NONE = 2'd0;
  localparam logic [1:0] BOM_LE   = 2'd1;
  localparam logic [1:0] BOM_BE   = 2'd2;

  // Classifier state
  logic [2:0]  class_r,    class_nxt;
  logic        nontext_r,  nontext_nxt;
  logic [2:0]  left_r,     left_nxt;
  logic [2:0]  seqlen_r,   seqlen_nxt;
  logic [30:0] acc_r,      acc_nxt;
  logic        u8fail_r,   u8fail_nxt;
  logic        atstart_r,  atstart_nxt;
  logic [1:0]  pos_r,      pos_nxt;
  logic [1:0]  bom_r,      bom_nxt;
  logic        u16fail_r,  u16fail_nxt;
  logic [7:0]  held_r,     held_nxt;
  logic        phase_r,    phase_nxt;

  logic        out_valid_r;
  logic [2:0]  out_type_r;
  logic [2:0]  code;
  logic        pop;
  logic [7:0]  b;
  logic [7:0]  hi, lo;

  assign out_valid     = out_valid_r;
  assign out_data_type = out_type_r;

  // A last byte waits until the output register is free
  assign pop_ready = !(head.entry.last_byte && out_valid_r && out_stall);
  assign pop       = head.valid && pop_ready;
  assign b         = head.entry.data_byte;

  always_comb begin
    class_nxt   = class_r | head.entry.cls;
    nontext_nxt = nontext_r | (head.entry.cls == CLS_NONE);
    left_nxt    = left_r;
    seqlen_nxt  = seqlen_r;
    acc_nxt     = acc_r;
    u8fail_nxt  = u8fail_r;
    atstart_nxt = atstart_r;
    bom_nxt     = bom_r;
    u16fail_nxt = u16fail_r;
    held_nxt    = held_r;
    phase_nxt   = phase_r;
    pos_nxt     = (pos_r < 2'd2) ? pos_r + 2'd1 : pos_r;
    hi          = (bom_r == BOM_BE) ? held_r : b;
    lo          = (bom_r == BOM_BE) ? b : held_r;
    code        = DT_BINARY;

    // UTF-8 decoder
    if (!u8fail_r) begin
      if (left_r == 3'd0) begin
        if (head.entry.cls != CLS_T) begin
          atstart_nxt = (pos_r == 2'd0);
          if (b[7:5] == 3'b110) begin
            acc_nxt = {26'd0, b[4:0]}; seqlen_nxt = 3'd2; left_nxt = 3'd1;
          end else if (b[7:4] == 4'b1110) begin
            acc_nxt = {27'd0, b[3:0]}; seqlen_nxt = 3'd3; left_nxt = 3'd2;
          end else if (b[7:3] == 5'b11110) begin
            acc_nxt = {28'd0, b[2:0]}; seqlen_nxt = 3'd4; left_nxt = 3'd3;
          end else if (b[7:2] == 6'b111110) begin
            acc_nxt = {29'd0, b[1:0]}; seqlen_nxt = 3'd5; left_nxt = 3'd4;
          end else if (b[7:1] == 7'b1111110) begin
            acc_nxt = {30'd0, b[0]};   seqlen_nxt = 3'd6; left_nxt = 3'd5;
          end else begin
            u8fail_nxt  = 1'b1;
            atstart_nxt = atstart_r;
          end
        end
      end else if (b[7:6] != 2'b10) begin
        u8fail_nxt = 1'b1;
      end else begin
        acc_nxt  = {acc_r[24:0], b[5:0]};
        left_nxt = left_r - 3'd1;
        // Complete sequence: overlong, surrogate and noncharacter checks
        if (left_nxt == 3'd0 &&
            (acc_nxt <= overlong_bound(seqlen_r) ||
             (acc_nxt >= 31'hD800 && acc_nxt <= 31'hDFFF) ||
             acc_nxt == 31'hFFFE || acc_nxt == 31'hFFFF)) begin
          u8fail_nxt = 1'b1;
        end
      end
    end

    // UTF-16 mark and unit check
    case (pos_r)
      2'd0: held_nxt = b;
      2'd1: begin
        if (held_r == 8'hFF && b == 8'hFE)      bom_nxt = BOM_LE;
        else if (held_r == 8'hFE && b == 8'hFF) bom_nxt = BOM_BE;
        else                                     u16fail_nxt = 1'b1;
      end
      default: begin
        if (!phase_r) begin
          held_nxt  = b;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (hi == 8'h00 && !lo[7] && text_class(lo) != CLS_T) begin
            u16fail_nxt = 1'b1;
          end
        end
      end
    endcase

    // Ranking of the three checks
    if (!nontext_nxt) begin
      code = (class_nxt <= 3'd1) ? DT_ASCII :
             (class_nxt <= 3'd3) ? DT_ISO8859 : DT_EXT;
    end else if (!u8fail_nxt && (left_nxt == 3'd0 || !atstart_nxt)) begin
      code = DT_UTF;
    end else if (pos_nxt >= 2'd2 && bom_nxt != BOM_NONE && !u16fail_nxt) begin
      code = DT_UTF;
    end else begin
      code = DT_BINARY;
    end

    // Clear everything after the buffer's result
    if (head.entry.last_byte) begin
      class_nxt   = '0;
      nontext_nxt = 1'b0;
      left_nxt    = '0;
      seqlen_nxt  = '0;
      acc_nxt     = '0;
      u8fail_nxt  = 1'b0;
      atstart_nxt = 1'b0;
      pos_nxt     = '0;
      bom_nxt     = BOM_NONE;
      u16fail_nxt = 1'b0;
      held_nxt    = '0;
      phase_nxt   = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r   <= '0;
      nontext_r <= 1'b0;
      left_r    <= '0;
      seqlen_r  <= '0;
      acc_r     <= '0;
      u8fail_r  <= 1'b0;
      atstart_r <= 1'b0;
      pos_r     <= '0;
      bom_r     <= BOM_NONE;
      u16fail_r <= 1'b0;
      held_r    <= '0;
      phase_r   <= 1'b0;
    end else if (pop) begin
      class_r   <= class_nxt;
      nontext_r <= nontext_nxt;
      left_r    <= left_nxt;
      seqlen_r  <= seqlen_nxt;
      acc_r     <= acc_nxt;
      u8fail_r  <= u8fail_nxt;
      atstart_r <= atstart_nxt;
      pos_r     <= pos_nxt;
      bom_r     <= bom_nxt;
      u16fail_r <= u16fail_nxt;
      held_r    <= held_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head.entry.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.entry.last_byte) begin
      out_type_r <= code;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/text_encoding_classifier_core.sv @@
// Text encoding classifier.
// Input channel: one byte per item (in_data_byte) with in_last_byte marking
// the final byte of a buffer; in_valid / in_stall handshake.
// Result channel: one item per buffer, out_data_type (0 ascii, 1 iso8859,
// 2 extended ascii, 3 unicode utf, 4 binary); out_valid / out_stall.
// Throughput: one byte per cycle while no held result blocks a last byte. The
// front end tags each byte with its text class and pushes it into a two-entry
// queue; the back end pops one entry per cycle unless a last byte waits for
// the output register, and updates the UTF-8 and UTF-16 checkers.
// Each accepted byte is registered in the queue before the back end pops it,
// and out_valid is registered at the pop of the buffer's last byte.
// When out_stall holds a result, bytes of the next buffer keep flowing until
// the back end reaches that buffer's last byte; then the queue fills and
// in_stall rises.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result
// and clears all classifier state; every result also clears that state.
`timescale 1ns / 1ps
`default_nettype none

module text_encoding_classifier_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_data_type
);
  import tec_pkg::*;

  logic        q_full;
  logic        push;
  logic        pop_ready;
  tec_entry_t  push_entry;
  tec_head_t   head;

  tec_front u_front (
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push         (push),
    .push_entry   (push_entry)
  );

  tec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop_ready  (pop_ready),
    .q_full     (q_full),
    .head       (head)
  );

  tec_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .out_stall     (out_stall),
    .pop_ready     (pop_ready),
    .out_valid     (out_valid),
    .out_data_type (out_data_type)
  );

endmodule

`default_nettype wire
